// ===== rtl/kwe_pkg.sv =====
// ---------------------------------------------------------------------------
// kwe_pkg
// Shared types and constants of the keyspace word enumerator.
// ---------------------------------------------------------------------------
package kwe_pkg;

   // field widths fixed by the interface
   localparam int CMD_W   = 2;
   localparam int IDX_W   = 6;
   localparam int CHAR_W  = 8;
   localparam int LEN_W   = 4;
   localparam int CS_W    = 7;
   localparam int CMP_W   = 9;   // wide enough for a digit plus one and for the table depth

   // configuration port
   localparam int CSR_AW  = 4;
   localparam int CSR_DW  = 32;

   // parameter defaults
   localparam int MAX_DIGITS_DEF  = 8;
   localparam int TABLE_DEPTH_DEF = 64;

   typedef enum logic [CMD_W-1:0] {
      CMD_LOAD    = 2'd0,
      CMD_RESTART = 2'd1,
      CMD_NEXT    = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      REG_MIN_LENGTH   = 2'd0,
      REG_MAX_LENGTH   = 2'd1,
      REG_CHARSET_SIZE = 2'd2
   } reg_type;

   typedef struct packed {
      logic [LEN_W-1:0] min_length;
      logic [LEN_W-1:0] max_length;
      logic [CS_W-1:0]  charset_size;
   } cfg_type;

   // what the odometer decides for one next request
   typedef struct packed {
      logic             bad_setup;
      logic             done_res;
      logic [LEN_W-1:0] word_length;
   } outcome_type;

endpackage

// ===== rtl/kwe_odometer.sv =====
// ---------------------------------------------------------------------------
// kwe_odometer
// Digit row, current length and finished flag, with the carry chain that
// steps the row once per next request.
// ---------------------------------------------------------------------------
module kwe_odometer
   import kwe_pkg::*;
#(
   parameter int MAX_DIGITS  = MAX_DIGITS_DEF,
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          step,
   input  logic                                          restart,
   input  cfg_type                                       cfg,
   output logic [MAX_DIGITS-1:0][$clog2(TABLE_DEPTH)-1:0] rd_addr,
   output outcome_type                                   outcome
);

   localparam int DW = $clog2(TABLE_DEPTH);

   logic [MAX_DIGITS-1:0][DW-1:0] digit_ff, digit_in;
   logic [LEN_W-1:0]              len_ff, len_in;
   logic                          fin_ff, fin_in;

   logic                          bad;
   logic                          jump;
   logic                          fin_eff;
   logic                          carry;
   logic [LEN_W-1:0]              len_eff;
   logic [LEN_W-1:0]              len_up;
   logic [MAX_DIGITS-1:0][DW-1:0] dig_eff;
   logic [MAX_DIGITS-1:0][DW-1:0] dig_inc;

   always_ff @(posedge clock) begin
      if (reset) begin
         digit_ff <= '0;
         len_ff   <= LEN_W'(1);
         fin_ff   <= 1'b0;
      end else begin
         digit_ff <= digit_in;
         len_ff   <= len_in;
         fin_ff   <= fin_in;
      end
   end

   always_comb begin
      bad = (cfg.min_length == '0)
         || (cfg.max_length > LEN_W'(MAX_DIGITS))
         || (cfg.max_length < cfg.min_length)
         || (cfg.charset_size < CS_W'(2))
         || (CMP_W'(cfg.charset_size) > CMP_W'(TABLE_DEPTH));

      // a length below the range restarts at the shortest length
      jump    = !fin_ff && (len_ff < cfg.min_length);
      len_eff = jump ? cfg.min_length : len_ff;
      dig_eff = jump ? '0 : digit_ff;
      fin_eff = fin_ff || (len_eff > cfg.max_length);
      len_up  = len_eff + LEN_W'(1);

      // ripple the carry from the last character towards the first
      dig_inc = dig_eff;
      carry   = 1'b1;
      for (int k = MAX_DIGITS - 1; k >= 0; k--) begin
         if ((LEN_W'(k) < len_eff) && carry) begin
            if (CMP_W'(dig_eff[k]) + CMP_W'(1) >= CMP_W'(cfg.charset_size)) begin
               dig_inc[k] = '0;
            end else begin
               dig_inc[k] = dig_eff[k] + DW'(1);
               carry      = 1'b0;
            end
         end
      end

      digit_in = digit_ff;
      len_in   = len_ff;
      fin_in   = fin_ff;
      if (restart) begin
         digit_in = '0;
         len_in   = cfg.min_length;
         fin_in   = 1'b0;
      end else if (step && !bad) begin
         if (fin_eff) begin
            digit_in = dig_eff;
            len_in   = len_eff;
            fin_in   = 1'b1;
         end else if (carry) begin
            // every digit wrapped: move on to the next length
            digit_in = '0;
            len_in   = len_up;
            fin_in   = len_up > cfg.max_length;
         end else begin
            digit_in = dig_inc;
            len_in   = len_eff;
         end
      end

      rd_addr             = dig_eff;
      outcome.bad_setup   = bad;
      outcome.done_res    = !bad && fin_eff;
      outcome.word_length = (bad || fin_eff) ? '0 : len_eff;
   end

endmodule

// ===== rtl/keyspace_word_enumerator.sv =====
// ---------------------------------------------------------------------------
// keyspace_word_enumerator
// Odometer word generator: walks every word over a loaded character table,
// length by length, one word per next request.
// ---------------------------------------------------------------------------
//  port group | direction | carries
//  req_*      | in        | request: cmd, char_index, char_value
//  rsp_*      | out       | result: word, word_length, done_res, bad_setup
//  csr_*      | in / out  | min_length, max_length, charset_size at 0x0/0x4/0x8
//
//  One request per cycle while req_stall is low; a next request's result is
//  registered in the table read register, then in the output register.
//  The table is held as one copy per character lane, so every lane reads its
//  own copy in the same cycle; loads write all copies.
//  Reset clears the digit row, length, flags and configuration, not the
//  data registers; the table is not cleared and needs no sweep.
//  A stalled result is held; the table read register takes one more result
//  behind it before req_stall rises.
// ---------------------------------------------------------------------------
module keyspace_word_enumerator
   import kwe_pkg::*;
#(
   parameter int MAX_DIGITS  = MAX_DIGITS_DEF,
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [CMD_W-1:0]           req_cmd,
   input  logic [IDX_W-1:0]           req_char_index,
   input  logic [CHAR_W-1:0]          req_char_value,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [CHAR_W*MAX_DIGITS-1:0] rsp_word,
   output logic [LEN_W-1:0]           rsp_word_length,
   output logic                       rsp_done_res,
   output logic                       rsp_bad_setup,
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic [CSR_AW-1:0]          csr_paddr,
   input  logic [CSR_DW-1:0]          csr_pwdata,
   output logic [CSR_DW-1:0]          csr_prdata,
   output logic                       csr_pready
);

   localparam int AW = $clog2(TABLE_DEPTH);

   cfg_type                       cfg_ff;
   reg_type                       csr_reg;
   logic                          csr_wr;

   logic                          accept;
   logic                          load_acc;
   logic                          next_acc;
   logic                          restart_acc;
   logic                          wr_ok;
   logic [AW-1:0]                 wr_addr;
   logic [MAX_DIGITS-1:0][AW-1:0] rd_addr;
   outcome_type                   outcome;

   logic                          s1_valid_ff, s1_valid_in;
   outcome_type                   s1_out_ff;
   logic [CHAR_W-1:0]             s1_char_ff [MAX_DIGITS];
   logic                          out_free;
   logic                          s1_free;
   logic [CHAR_W*MAX_DIGITS-1:0]  word_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W*MAX_DIGITS-1:0]  rsp_word_ff;
   outcome_type                   rsp_out_ff;

   // configuration registers
   assign csr_reg    = reg_type'(csr_paddr[3:2]);
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_length   <= LEN_W'(1);
         cfg_ff.max_length   <= LEN_W'(1);
         cfg_ff.charset_size <= CS_W'(2);
      end else if (csr_wr) begin
         case (csr_reg)
            REG_MIN_LENGTH:   cfg_ff.min_length   <= csr_pwdata[LEN_W-1:0];
            REG_MAX_LENGTH:   cfg_ff.max_length   <= csr_pwdata[LEN_W-1:0];
            REG_CHARSET_SIZE: cfg_ff.charset_size <= csr_pwdata[CS_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_reg)
         REG_MIN_LENGTH:   csr_prdata = CSR_DW'(cfg_ff.min_length);
         REG_MAX_LENGTH:   csr_prdata = CSR_DW'(cfg_ff.max_length);
         REG_CHARSET_SIZE: csr_prdata = CSR_DW'(cfg_ff.charset_size);
         default:          csr_prdata = '0;
      endcase
   end

   // request decode
   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign s1_free     = !s1_valid_ff || out_free;
   assign req_stall   = !s1_free;
   assign accept      = req_valid && !req_stall;
   assign load_acc    = accept && (cmd_type'(req_cmd) == CMD_LOAD);
   assign restart_acc = accept && (cmd_type'(req_cmd) == CMD_RESTART);
   assign next_acc    = accept && (cmd_type'(req_cmd) == CMD_NEXT);

   // drop loads beyond the table
   assign wr_ok   = CMP_W'(req_char_index) < CMP_W'(TABLE_DEPTH);
   assign wr_addr = AW'(req_char_index);

   kwe_odometer #(
      .MAX_DIGITS  (MAX_DIGITS),
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_odometer (
      .clock   (clock),
      .reset   (reset),
      .step    (next_acc),
      .restart (restart_acc),
      .cfg     (cfg_ff),
      .rd_addr (rd_addr),
      .outcome (outcome)
   );

   // one table copy per character lane
   for (genvar k = 0; k < MAX_DIGITS; k++) begin : g_lane
      logic [CHAR_W-1:0] mem [TABLE_DEPTH];

      always_ff @(posedge clock) begin
         if (load_acc && wr_ok) begin
            mem[wr_addr] <= req_char_value;
         end
         if (next_acc) begin
            s1_char_ff[k] <= mem[rd_addr[k]];
         end
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (next_acc) begin
         s1_valid_in = 1'b1;
      end else if (out_free) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = out_free ? s1_valid_ff : rsp_valid_ff;

      // zero the bytes past the word's length
      for (int k = 0; k < MAX_DIGITS; k++) begin
         word_in[k*CHAR_W +: CHAR_W] =
            (LEN_W'(k) < s1_out_ff.word_length) ? s1_char_ff[k] : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (next_acc) begin
         s1_out_ff <= outcome;
      end
      if (out_free && s1_valid_ff) begin
         rsp_word_ff <= word_in;
         rsp_out_ff  <= s1_out_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_word        = rsp_word_ff;
   assign rsp_word_length = rsp_out_ff.word_length;
   assign rsp_done_res    = rsp_out_ff.done_res;
   assign rsp_bad_setup   = rsp_out_ff.bad_setup;

endmodule

// ===== rtl/kwe_checker.sv =====
// ---------------------------------------------------------------------------
// kwe_checker
// Port-level checks on the result channel of the word enumerator.
// ---------------------------------------------------------------------------
module kwe_checker
   import kwe_pkg::*;
#(
   parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
   input logic                         clock,
   input logic                         reset,
   input logic                         rsp_valid,
   input logic                         rsp_stall,
   input logic [CHAR_W*MAX_DIGITS-1:0] rsp_word,
   input logic [LEN_W-1:0]             rsp_word_length,
   input logic                         rsp_done_res,
   input logic                         rsp_bad_setup
);

   // a stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word)
         && $stable(rsp_word_length))
      else $error("stalled result changed");

   // nothing comes out straight after reset
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // error and done carry no word
   a_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_bad_setup || rsp_done_res) |->
         rsp_word == '0 && rsp_word_length == '0
         && !(rsp_bad_setup && rsp_done_res))
      else $error("flagged result carries a word");

   // a real word has a length in range
   a_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_bad_setup && !rsp_done_res |->
         rsp_word_length != '0 && rsp_word_length <= LEN_W'(MAX_DIGITS))
      else $error("word length out of range");

   // bytes past the length are zero
   a_pad: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_word >> (CHAR_W * rsp_word_length)) == '0)
      else $error("bytes past word length not zero");

endmodule

bind keyspace_word_enumerator kwe_checker #(
   .MAX_DIGITS (MAX_DIGITS)
) u_kwe_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_word        (rsp_word),
   .rsp_word_length (rsp_word_length),
   .rsp_done_res    (rsp_done_res),
   .rsp_bad_setup   (rsp_bad_setup)
);

// ===== bench/keyspace_word_enumerator_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyspace_word_enumerator_test
// Self-checking bench for the odometer word generator. Loads the whole
// character table first, walks a directed table of requests and register
// settings, then runs random phases of requests under random idling on both
// channels. Each word is checked against the plan or an in-bench odometer model.
// ----------------------------------------------------------------------------
module keyspace_word_enumerator_test;
   import kwe_pkg::*;

   localparam int CLK_HALF     = 6;
   localparam int DIGITS       = MAX_DIGITS_DEF;
   localparam int DEPTH        = TABLE_DEPTH_DEF;
   localparam int RANDOM_ITEMS = 560;
   localparam int QUIET_FROM   = 480;
   localparam int SETTLE       = 6;
   localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

   typedef struct packed {
      logic [CHAR_W*DIGITS-1:0] word;
      logic [LEN_W-1:0]         word_length;
      logic                     done_res;
      logic                     bad_setup;
   } word_result_type;

   typedef enum logic {ROW_REQ, ROW_CFG} row_kind_type;

   typedef struct {
      row_kind_type       kind;
      logic [CMD_W-1:0]   cmd;
      logic [IDX_W-1:0]   idx;
      logic [CHAR_W-1:0]  val;
      reg_type            csr;
      logic [CSR_DW-1:0]  data;
      bit                 typed;
      word_result_type    want;
   } plan_row_type;

   logic                     clock = 1'b0;
   logic                     reset;
   logic                     req_valid;
   logic                     req_stall;
   logic [CMD_W-1:0]         req_cmd;
   logic [IDX_W-1:0]         req_char_index;
   logic [CHAR_W-1:0]        req_char_value;
   logic                     rsp_valid;
   logic                     rsp_stall;
   logic [CHAR_W*DIGITS-1:0] rsp_word;
   logic [LEN_W-1:0]         rsp_word_length;
   logic                     rsp_done_res;
   logic                     rsp_bad_setup;
   logic                     csr_psel;
   logic                     csr_penable;
   logic                     csr_pwrite;
   logic [CSR_AW-1:0]        csr_paddr;
   logic [CSR_DW-1:0]        csr_pwdata;
   logic [CSR_DW-1:0]        csr_prdata;
   logic                     csr_pready;

   // odometer model state
   logic [CHAR_W-1:0] table_copy [DEPTH];
   int unsigned       digit_row [DIGITS];
   int unsigned       run_length;
   bit                run_over;
   int unsigned       cfg_min;
   int unsigned       cfg_max;
   int unsigned       cfg_chars;

   word_result_type pending_words [$];
   word_result_type head;
   int unsigned     failures;
   bit              quiet;

   keyspace_word_enumerator i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_cmd         (req_cmd),
      .req_char_index  (req_char_index),
      .req_char_value  (req_char_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_word        (rsp_word),
      .rsp_word_length (rsp_word_length),
      .rsp_done_res    (rsp_done_res),
      .rsp_bad_setup   (rsp_bad_setup),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready)
   );

   always begin
      #CLK_HALF clock = 1'b1;
      #CLK_HALF clock = 1'b0;
   end

   initial begin
      #5_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   function automatic bit setup_broken();
      return cfg_min == 0 || cfg_max > DIGITS || cfg_max < cfg_min ||
             cfg_chars < 2 || cfg_chars > DEPTH;
   endfunction

   // Apply one request to the model; returns 1 when it yields a result.
   function automatic bit odometer_step(input logic [CMD_W-1:0] cmd,
                                        input logic [IDX_W-1:0] idx,
                                        input logic [CHAR_W-1:0] val,
                                        output word_result_type r);
      int unsigned k;
      r = '0;
      case (cmd)
         CMD_LOAD: begin
            table_copy[idx] = val;
            return 0;
         end
         CMD_RESTART: begin
            digit_row  = '{default: 0};
            run_length = cfg_min;
            run_over   = 1'b0;
            return 0;
         end
         CMD_NEXT: begin
            if (setup_broken()) begin
               r.bad_setup = 1'b1;
               return 1;
            end
            if (!run_over && run_length < cfg_min) begin
               run_length = cfg_min;
               digit_row  = '{default: 0};
            end
            if (!run_over && run_length > cfg_max)
               run_over = 1'b1;
            if (run_over) begin
               r.done_res = 1'b1;
               return 1;
            end
            for (k = 0; k < run_length; k++)
               r.word[8*k +: 8] = table_copy[digit_row[k]];
            r.word_length = LEN_W'(run_length);
            // carry from the last digit towards the first
            k = run_length;
            forever begin
               if (k == 0) begin
                  digit_row = '{default: 0};
                  run_length++;
                  if (run_length > cfg_max)
                     run_over = 1'b1;
                  break;
               end
               k--;
               if (digit_row[k] + 1 >= cfg_chars) begin
                  digit_row[k] = 0;
               end else begin
                  digit_row[k]++;
                  break;
               end
            end
            return 1;
         end
         default: return 0;
      endcase
   endfunction

   function automatic plan_row_type req_row(logic [CMD_W-1:0] cmd, logic [IDX_W-1:0] idx,
                                            logic [CHAR_W-1:0] val);
      plan_row_type p;
      p.kind  = ROW_REQ;
      p.cmd   = cmd;
      p.idx   = idx;
      p.val   = val;
      p.csr   = REG_MIN_LENGTH;
      p.data  = '0;
      p.typed = 1'b0;
      p.want  = '0;
      return p;
   endfunction

   function automatic plan_row_type word_row(logic [CHAR_W*DIGITS-1:0] w, int unsigned len,
                                             bit done, bit bad);
      plan_row_type p;
      p = req_row(CMD_NEXT, IDX_W'($urandom_range(0, 63)), CHAR_W'($urandom_range(0, 255)));
      p.typed = 1'b1;
      p.want  = '{word: w, word_length: LEN_W'(len), done_res: done, bad_setup: bad};
      return p;
   endfunction

   function automatic plan_row_type cfg_row(reg_type csr, int unsigned v);
      plan_row_type p;
      p = req_row(CMD_LOAD, '0, '0);
      p.kind = ROW_CFG;
      p.csr  = csr;
      p.data = v;
      return p;
   endfunction

   task automatic idle(int unsigned n);
      repeat (n) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
   endtask

   task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] idx,
                               input logic [CHAR_W-1:0] val, input bit typed,
                               input word_result_type want);
      word_result_type predicted;
      @(negedge clock);
      req_valid      <= 1'b1;
      req_cmd        <= cmd;
      req_char_index <= idx;
      req_char_value <= val;
      do @(posedge clock); while (req_stall);
      if (odometer_step(cmd, idx, val, predicted))
         pending_words.push_back(typed ? want : predicted);
   endtask

   // hold the sender until every word has arrived and the pipe is empty
   task automatic settle();
      idle(1);
      while (pending_words.size() != 0)
         idle(1);
      idle(SETTLE);
   endtask

   task automatic write_csr(reg_type csr, logic [CSR_DW-1:0] v);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {csr, 2'b00};
      csr_pwdata  <= v;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (csr)
         REG_MIN_LENGTH:   cfg_min   = 32'(v[LEN_W-1:0]);
         REG_MAX_LENGTH:   cfg_max   = 32'(v[LEN_W-1:0]);
         REG_CHARSET_SIZE: cfg_chars = 32'(v[CS_W-1:0]);
         default: ;
      endcase
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // result side: random stall bursts, none once the run goes quiet
   initial begin
      rsp_stall <= 1'b0;
      forever begin
         repeat ($urandom_range(1, 20)) @(negedge clock) rsp_stall <= 1'b0;
         if (!quiet && $urandom_range(0, 1) == 1)
            repeat ($urandom_range(1, 12)) @(negedge clock) rsp_stall <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_words.size() == 0) begin
            $display("%0t: unexpected word %h length %0d done %b bad %b", $time,
                     rsp_word, rsp_word_length, rsp_done_res, rsp_bad_setup);
            failures++;
         end else begin
            head = pending_words.pop_front();
            if (rsp_word !== head.word) begin
               $display("%0t: word expected %h got %h", $time, head.word, rsp_word);
               failures++;
            end
            if (rsp_word_length !== head.word_length) begin
               $display("%0t: word_length expected %0d got %0d", $time,
                        head.word_length, rsp_word_length);
               failures++;
            end
            if (rsp_done_res !== head.done_res) begin
               $display("%0t: done_res expected %b got %b", $time,
                        head.done_res, rsp_done_res);
               failures++;
            end
            if (rsp_bad_setup !== head.bad_setup) begin
               $display("%0t: bad_setup expected %b got %b", $time,
                        head.bad_setup, rsp_bad_setup);
               failures++;
            end
         end
      end
   end

   initial begin
      plan_row_type     plan [$];
      word_result_type  none;
      logic [CMD_W-1:0] cmd;
      int unsigned      i, pick, min_len, max_len, chars, random_sent;

      none           = '0;
      failures       = 0;
      quiet          = 1'b0;
      random_sent    = 0;
      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_cmd        <= CMD_LOAD;
      req_char_index <= '0;
      req_char_value <= '0;
      csr_psel       <= 1'b0;
      csr_penable    <= 1'b0;
      csr_pwrite     <= 1'b0;
      csr_paddr      <= '0;
      csr_pwdata     <= '0;
      digit_row      = '{default: 0};
      run_length     = 1;
      run_over       = 1'b0;
      cfg_min        = 1;
      cfg_max        = 1;
      cfg_chars      = 2;

      repeat (2) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // write every table entry so that no read ever hits an empty one
      for (i = 0; i < DEPTH; i++)
         send_request(CMD_LOAD, IDX_W'(i), CHAR_W'($urandom_range(0, 255)), 1'b0, none);

      plan.push_back(req_row(CMD_LOAD, 6'd0, 8'h41));
      plan.push_back(req_row(CMD_LOAD, 6'd1, 8'hFF));
      plan.push_back(req_row(CMD_LOAD, 6'd63, 8'h00));
      plan.push_back(word_row(64'h41, 1, 1'b0, 1'b0));
      plan.push_back(word_row(64'hFF, 1, 1'b0, 1'b0));
      plan.push_back(word_row(64'h0, 0, 1'b1, 1'b0));
      plan.push_back(req_row(CMD_SPARE, 6'd63, 8'hFF));
      plan.push_back(word_row(64'h0, 0, 1'b1, 1'b0));
      plan.push_back(req_row(CMD_RESTART, 6'd0, 8'h00));
      plan.push_back(word_row(64'h41, 1, 1'b0, 1'b0));
      plan.push_back(cfg_row(REG_MAX_LENGTH, 2));
      plan.push_back(word_row(64'hFF, 1, 1'b0, 1'b0));
      plan.push_back(word_row(64'h4141, 2, 1'b0, 1'b0));
      plan.push_back(word_row(64'hFF41, 2, 1'b0, 1'b0));
      // shrink the range below the running length
      plan.push_back(cfg_row(REG_MAX_LENGTH, 1));
      plan.push_back(word_row(64'h0, 0, 1'b1, 1'b0));
      plan.push_back(cfg_row(REG_MAX_LENGTH, 0));
      plan.push_back(word_row(64'h0, 0, 1'b0, 1'b1));
      plan.push_back(cfg_row(REG_MAX_LENGTH, 15));
      plan.push_back(word_row(64'h0, 0, 1'b0, 1'b1));
      plan.push_back(cfg_row(REG_MAX_LENGTH, 8));
      plan.push_back(cfg_row(REG_MIN_LENGTH, 0));
      plan.push_back(word_row(64'h0, 0, 1'b0, 1'b1));
      plan.push_back(cfg_row(REG_MIN_LENGTH, 8));
      plan.push_back(cfg_row(REG_CHARSET_SIZE, 1));
      plan.push_back(word_row(64'h0, 0, 1'b0, 1'b1));
      plan.push_back(cfg_row(REG_CHARSET_SIZE, 0));
      plan.push_back(word_row(64'h0, 0, 1'b0, 1'b1));
      plan.push_back(cfg_row(REG_CHARSET_SIZE, 65));
      plan.push_back(word_row(64'h0, 0, 1'b0, 1'b1));
      plan.push_back(cfg_row(REG_CHARSET_SIZE, 127));
      plan.push_back(word_row(64'h0, 0, 1'b0, 1'b1));
      plan.push_back(cfg_row(REG_CHARSET_SIZE, 64));
      plan.push_back(word_row(64'h0, 0, 1'b1, 1'b0));
      plan.push_back(req_row(CMD_RESTART, 6'd63, 8'hFF));
      plan.push_back(word_row(64'h4141_4141_4141_4141, 8, 1'b0, 1'b0));
      plan.push_back(req_row(CMD_NEXT, 6'd0, 8'h00));
      // raise the minimum above the running length
      plan.push_back(cfg_row(REG_MIN_LENGTH, 1));
      plan.push_back(cfg_row(REG_MAX_LENGTH, 3));
      plan.push_back(cfg_row(REG_CHARSET_SIZE, 2));
      plan.push_back(req_row(CMD_RESTART, 6'd0, 8'h00));
      plan.push_back(word_row(64'h41, 1, 1'b0, 1'b0));
      plan.push_back(cfg_row(REG_MIN_LENGTH, 3));
      plan.push_back(req_row(CMD_NEXT, 6'd0, 8'h00));

      foreach (plan[j]) begin
         if (plan[j].kind == ROW_CFG) begin
            settle();
            write_csr(plan[j].csr, plan[j].data);
         end else begin
            send_request(plan[j].cmd, plan[j].idx, plan[j].val, plan[j].typed, plan[j].want);
         end
      end

      while (random_sent < RANDOM_ITEMS) begin
         settle();
         pick = $urandom_range(0, 9);
         if (pick == 0) begin
            min_len = $urandom_range(0, 15);
            max_len = $urandom_range(0, 15);
            chars   = $urandom_range(0, 127);
         end else if (pick < 5) begin
            // small keyspace, so that whole runs finish
            chars   = $urandom_range(2, 3);
            min_len = $urandom_range(1, 2);
            max_len = $urandom_range(min_len, 3);
         end else begin
            chars   = $urandom_range(2, DEPTH);
            min_len = $urandom_range(1, DIGITS);
            max_len = $urandom_range(min_len, DIGITS);
         end
         write_csr(REG_CHARSET_SIZE, chars);
         write_csr(REG_MIN_LENGTH, min_len);
         write_csr(REG_MAX_LENGTH, max_len);
         if ($urandom_range(0, 2) != 0) begin
            send_request(CMD_RESTART, IDX_W'($urandom_range(0, 63)),
                         CHAR_W'($urandom_range(0, 255)), 1'b0, none);
            random_sent++;
         end
         repeat ($urandom_range(10, 40)) begin
            if (!quiet && $urandom_range(0, 5) == 0)
               idle($urandom_range(1, 12));
            pick = $urandom_range(0, 99);
            if (pick < 75)
               cmd = CMD_NEXT;
            else if (pick < 83)
               cmd = CMD_LOAD;
            else if (pick < 93)
               cmd = CMD_RESTART;
            else
               cmd = CMD_SPARE;
            send_request(cmd, IDX_W'($urandom_range(0, 63)),
                         CHAR_W'($urandom_range(0, 255)), 1'b0, none);
            if (cmd != CMD_SPARE)
               random_sent++;
            if (random_sent >= QUIET_FROM)
               quiet = 1'b1;
         end
      end

      idle(1);
      i = 0;
      while (pending_words.size() != 0 && i < 5000) begin
         idle(1);
         i++;
      end
      idle(SETTLE);
      if (pending_words.size() != 0) begin
         $display("%0t: %0d expected words never arrived", $time, pending_words.size());
         failures++;
      end

      if (failures == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/kwe_pkg.sv
rtl/kwe_odometer.sv
rtl/keyspace_word_enumerator.sv
rtl/kwe_checker.sv
bench/keyspace_word_enumerator_test.sv
